FILE: hw/rtl/dmxrdm_pkg.sv
// shared types and constants for the dmx512 / rdm frame receiver
package dmxrdm_pkg;

    localparam int unsigned DEF_FRAME_SLOTS = 512;

    localparam logic [7:0] SC_DMX = 8'h00;
    localparam logic [7:0] SC_RDM = 8'hCC;

    localparam int unsigned FIRST_CH_W  = 9;
    localparam int unsigned CH_COUNT_W  = 8;
    localparam int unsigned CFG_DATA_W  = 9;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_CHANNEL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 1'b1;

    localparam logic [FIRST_CH_W-1:0] FIRST_CH_RESET = 9'd1;
    localparam logic [CH_COUNT_W-1:0] CH_COUNT_RESET = 8'd1;

    typedef enum logic [2:0] {
        FT_NONE = 3'b001,
        FT_DMX  = 3'b010,
        FT_RDM  = 3'b100
    } frame_type_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_index;
        logic [7:0] out_value;
        logic       frame_kind;
        logic       frame_done;
        logic       frame_abort;
    } result_t;

endpackage

FILE: hw/rtl/dmx_rdm_frame_receiver.sv
// dmx512 / rdm frame receiver: start code decode, slot counting, window capture
// a result word is registered in the result register, or in the skid entry while stalled
// throughput: one word per cycle while the skid is empty; one pass of compares and a counter
// output side: result register plus one skid entry, so input flows until the skid fills
// reset: receiver disarmed, no frame open, slot count zero, first_channel = 1,
// channel_count = 1, no result pending
module dmx_rdm_frame_receiver #(
    parameter int unsigned FRAME_SLOTS = dmxrdm_pkg::DEF_FRAME_SLOTS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic [7:0]                            rx_byte,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output logic                                  out_valid,
    output logic [7:0]                            out_index,
    output logic [7:0]                            out_value,
    output logic                                  frame_kind,
    output logic                                  frame_done,
    output logic                                  frame_abort,
    output logic                                  last_of_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dmxrdm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dmxrdm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dmxrdm_pkg::*;

    // slot counter must hold FRAME_SLOTS and any rdm length
    localparam int unsigned SLOT_LIM_W = $clog2(FRAME_SLOTS + 1);
    localparam int unsigned SW = (SLOT_LIM_W > 8) ? SLOT_LIM_W : 8;
    localparam int unsigned CW = ((SW > 10) ? SW : 10) + 1;

    logic [FIRST_CH_W-1:0] first_channel_reg;
    logic [CH_COUNT_W-1:0] channel_count_reg;

    logic        armed_reg, armed_next;
    frame_type_t ft_reg, ft_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [7:0]  len_reg, len_next;

    result_t res_reg, skid_reg, res_new;
    logic    res_valid_reg, res_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    res_load, skid_load, res_from_skid;

    logic in_fire, push;

    logic [FIRST_CH_W-1:0] first_eff;
    logic [CW-1:0] s_w, first_w, end_w, s1_w;
    logic          in_win;
    logic [7:0]    win_index;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_channel_reg <= FIRST_CH_RESET;
            channel_count_reg <= CH_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FIRST_CHANNEL: first_channel_reg <= cfg_data[FIRST_CH_W-1:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CH_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // window arithmetic on widened values
    assign first_eff = (first_channel_reg == '0) ? FIRST_CH_W'(1) : first_channel_reg;
    assign s_w       = CW'(slot_reg);
    assign first_w   = CW'(first_eff);
    assign end_w     = first_w + CW'(channel_count_reg);
    assign s1_w      = s_w + CW'(1);
    assign in_win    = (s_w >= first_w) && (s_w < end_w);
    assign win_index = 8'(s_w - first_w + CW'(1));

    always_comb
    begin
        armed_next = armed_reg;
        ft_next    = ft_reg;
        slot_next  = slot_reg;
        len_next   = len_reg;
        push       = 1'b0;
        res_new    = '0;
        if (in_fire)
        begin
            if (kind)
            begin
                armed_next = 1'b1;
                ft_next    = FT_NONE;
                slot_next  = '0;
            end
            else if (armed_reg)
            begin
                if (slot_reg == '0)
                begin
                    if (rx_byte == SC_RDM || rx_byte == SC_DMX)
                    begin
                        ft_next  = (rx_byte == SC_RDM) ? FT_RDM : FT_DMX;
                        if (rx_byte == SC_RDM)
                            len_next = '0;
                        slot_next = SW'(1);
                        push      = 1'b1;
                        res_new.out_valid  = 1'b1;
                        res_new.out_value  = rx_byte;
                        res_new.frame_kind = (rx_byte == SC_RDM);
                    end
                end
                else
                begin
                    case (ft_reg)
                        FT_DMX:
                        begin
                            if (s_w >= CW'(FRAME_SLOTS))
                            begin
                                armed_next = 1'b0;
                                ft_next    = FT_NONE;
                                slot_next  = '0;
                                push       = 1'b1;
                                res_new.frame_abort = 1'b1;
                            end
                            else if (s1_w >= end_w)
                            begin
                                // last slot of the window closes the frame
                                armed_next = 1'b0;
                                ft_next    = FT_NONE;
                                slot_next  = '0;
                                push       = 1'b1;
                                res_new.out_valid  = in_win;
                                res_new.out_index  = in_win ? win_index : '0;
                                res_new.out_value  = in_win ? rx_byte : '0;
                                res_new.frame_done = 1'b1;
                            end
                            else
                            begin
                                slot_next = slot_reg + SW'(1);
                                if (in_win)
                                begin
                                    push = 1'b1;
                                    res_new.out_valid = 1'b1;
                                    res_new.out_index = win_index;
                                    res_new.out_value = rx_byte;
                                end
                            end
                        end
                        FT_RDM:
                        begin
                            if (slot_reg == SW'(1))
                            begin
                                len_next  = rx_byte;
                                slot_next = SW'(2);
                                if (rx_byte > 8'd1)
                                begin
                                    push = 1'b1;
                                    res_new.out_valid  = 1'b1;
                                    res_new.out_index  = 8'd1;
                                    res_new.out_value  = rx_byte;
                                    res_new.frame_kind = 1'b1;
                                end
                            end
                            else if (slot_reg < SW'(len_reg))
                            begin
                                slot_next = slot_reg + SW'(1);
                                push      = 1'b1;
                                res_new.out_valid  = 1'b1;
                                res_new.out_index  = slot_reg[7:0];
                                res_new.out_value  = rx_byte;
                                res_new.frame_kind = 1'b1;
                            end
                            else
                            begin
                                armed_next = 1'b0;
                                ft_next    = FT_NONE;
                                slot_next  = '0;
                                push       = 1'b1;
                                res_new.frame_kind = 1'b1;
                                res_new.frame_done = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // result register with one skid entry behind it
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        skid_valid_next = skid_valid_reg;
        res_load        = 1'b0;
        skid_load       = 1'b0;
        res_from_skid   = 1'b0;
        if (!res_valid_reg || res_ready)
        begin
            if (skid_valid_reg)
            begin
                res_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                res_load        = 1'b1;
                res_from_skid   = 1'b1;
            end
            else
            begin
                res_valid_next = push;
                res_load       = push;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            ft_reg         <= FT_NONE;
            slot_reg       <= '0;
            len_reg        <= '0;
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            armed_reg      <= armed_next;
            ft_reg         <= ft_next;
            slot_reg       <= slot_next;
            len_reg        <= len_next;
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res_from_skid ? skid_reg : res_new;
        if (skid_load)
            skid_reg <= res_new;
    end

    assign res_valid    = res_valid_reg;
    assign out_valid    = res_reg.out_valid;
    assign out_index    = res_reg.out_index;
    assign out_value    = res_reg.out_value;
    assign frame_kind   = res_reg.frame_kind;
    assign frame_done   = res_reg.frame_done;
    assign frame_abort  = res_reg.frame_abort;
    assign last_of_item = 1'b1;

    a_skid_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> res_valid_reg)
        else $error("skid entry held while result register empty");

    a_disarmed_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |-> (ft_reg == FT_NONE) && (slot_reg == '0))
        else $error("frame state left open while disarmed");

    a_no_frame_no_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (ft_reg == FT_NONE) |-> (slot_reg == '0))
        else $error("slot count running with no frame open");

    a_empty_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.out_valid) |->
        (res_reg.out_index == '0) && (res_reg.out_value == '0))
        else $error("empty result word carries index or value");

    a_abort_is_dmx: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.frame_abort) |->
        !res_reg.frame_kind && !res_reg.frame_done && !res_reg.out_valid)
        else $error("abort word flagged as rdm, done or carrying data");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> res_valid_reg && $stable(res_reg))
        else $error("stalled result word changed");

endmodule

FILE: test/dmx_rdm_frame_receiver_tb.sv
// testbench for the dmx512 / rdm frame receiver: scripted and random byte streams checked live
module dmx_rdm_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmxrdm_pkg::*;

    localparam logic        KIND_BYTE    = 1'b0;
    localparam logic        KIND_BREAK   = 1'b1;
    localparam int unsigned SLOT_LIMIT   = DEF_FRAME_SLOTS;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned PHASE_WORDS  = 130;
    localparam int unsigned RANDOM_WORDS = 1300;
    localparam int unsigned PRINT_CAP    = 100;

    typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_WORD} row_check_t;
    typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MASK} stall_mode_t;

    typedef struct packed {
        logic       k;
        logic [7:0] b;
        row_check_t chk;
        result_t    want;
    } stim_row_t;

    localparam result_t DMX_OPEN = '{1'b1, 8'd0, SC_DMX, 1'b0, 1'b0, 1'b0};
    localparam result_t RDM_OPEN = '{1'b1, 8'd0, SC_RDM, 1'b1, 1'b0, 1'b0};
    localparam result_t RDM_END  = '{1'b0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0};

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   kind;
    logic [7:0]             rx_byte;
    logic                   res_valid;
    logic                   res_ready;
    logic                   out_valid;
    logic [7:0]             out_index;
    logic [7:0]             out_value;
    logic                   frame_kind;
    logic                   frame_done;
    logic                   frame_abort;
    logic                   last_of_item;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // receiver state as the block should hold it
    bit                     rx_armed  = 1'b0;
    frame_type_t            rx_frame  = FT_NONE;
    int unsigned            rx_slot   = 0;
    logic [7:0]             rdm_len   = '0;
    logic [FIRST_CH_W-1:0]  win_first = FIRST_CH_RESET;
    logic [CH_COUNT_W-1:0]  win_count = CH_COUNT_RESET;

    result_t                due_results [$];
    int unsigned            mismatches  = 0;
    int unsigned            live_words  = 0;
    int unsigned            burst_left  = 0;
    bit                     steady      = 1'b0;
    int unsigned            hold_asks   = 0;

    stim_row_t script [25] = '{
        '{KIND_BYTE,  8'h00, CHK_NONE, '0},           // not armed yet
        '{KIND_BREAK, 8'h00, CHK_NONE, '0},
        '{KIND_BYTE,  8'h55, CHK_NONE, '0},           // unknown start code, stays armed
        '{KIND_BYTE,  SC_DMX, CHK_WORD, DMX_OPEN},
        '{KIND_BYTE,  8'hFF, CHK_WORD, '{1'b1, 8'd1, 8'hFF, 1'b0, 1'b1, 1'b0}},
        '{KIND_BYTE,  8'h12, CHK_NONE, '0},           // disarmed after frame end
        '{KIND_BREAK, 8'hFF, CHK_NONE, '0},
        '{KIND_BYTE,  SC_RDM, CHK_WORD, RDM_OPEN},
        '{KIND_BYTE,  8'h01, CHK_NONE, '0},           // short length is not emitted
        '{KIND_BYTE,  8'h77, CHK_WORD, RDM_END},
        '{KIND_BREAK, 8'h00, CHK_NONE, '0},
        '{KIND_BYTE,  SC_RDM, CHK_WORD, RDM_OPEN},
        '{KIND_BYTE,  8'h04, CHK_WORD, '{1'b1, 8'd1, 8'h04, 1'b1, 1'b0, 1'b0}},
        '{KIND_BYTE,  8'hAA, CHK_PRED, '0},
        '{KIND_BYTE,  8'h00, CHK_PRED, '0},
        '{KIND_BYTE,  8'h33, CHK_WORD, RDM_END},
        '{KIND_BREAK, 8'h00, CHK_NONE, '0},
        '{KIND_BYTE,  SC_DMX, CHK_WORD, DMX_OPEN},
        '{KIND_BREAK, 8'h00, CHK_NONE, '0},           // break drops the open dmx frame
        '{KIND_BYTE,  SC_RDM, CHK_WORD, RDM_OPEN},
        '{KIND_BREAK, 8'hFF, CHK_NONE, '0},           // break drops the open rdm frame
        '{KIND_BYTE,  SC_RDM, CHK_WORD, RDM_OPEN},
        '{KIND_BYTE,  8'h00, CHK_NONE, '0},           // zero length
        '{KIND_BYTE,  8'hFF, CHK_WORD, RDM_END},
        '{KIND_BREAK, 8'h00, CHK_NONE, '0}
    };

    dmx_rdm_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .out_valid    (out_valid),
        .out_index    (out_index),
        .out_value    (out_value),
        .frame_kind   (frame_kind),
        .frame_done   (frame_done),
        .frame_abort  (frame_abort),
        .last_of_item (last_of_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("dmx_rdm_frame_receiver_tb: done, errors");
        $finish;
    end

    function automatic void drop_frame();
        rx_armed = 1'b0;
        rx_frame = FT_NONE;
        rx_slot  = 0;
    endfunction

    // advances the receiver state by one word, returns 1 when a result word is due
    function automatic bit rx_decode(input logic k, input logic [7:0] b, output result_t r);
        int unsigned s;
        int unsigned first;
        int unsigned stop;
        bit          in_win;
        r = '0;
        if (k == KIND_BREAK)
        begin
            rx_armed = 1'b1;
            rx_frame = FT_NONE;
            rx_slot  = 0;
            return 1'b0;
        end
        if (!rx_armed)
            return 1'b0;
        s = rx_slot;
        if (s == 0)
        begin
            if (b == SC_RDM)
            begin
                rx_frame = FT_RDM;
                rdm_len  = '0;
            end
            else if (b == SC_DMX)
                rx_frame = FT_DMX;
            else
                return 1'b0;
            rx_slot      = 1;
            r.out_valid  = 1'b1;
            r.out_value  = b;
            r.frame_kind = (rx_frame == FT_RDM);
            return 1'b1;
        end
        if (rx_frame == FT_DMX)
        begin
            first = (win_first == 0) ? 1 : win_first;
            stop  = first + win_count;
            if (s >= SLOT_LIMIT)
            begin
                drop_frame();
                r.frame_abort = 1'b1;
                return 1'b1;
            end
            in_win = (s >= first) && (s < stop);
            if (in_win)
            begin
                r.out_valid = 1'b1;
                r.out_index = 8'(s - first + 1);
                r.out_value = b;
            end
            rx_slot = s + 1;
            if (s + 1 >= stop)
            begin
                drop_frame();
                r.frame_done = 1'b1;
                return 1'b1;
            end
            return in_win;
        end
        if (rx_frame == FT_RDM)
        begin
            r.frame_kind = 1'b1;
            if (s == 1)
            begin
                rdm_len = b;
                rx_slot = 2;
                if (b > 1)
                begin
                    r.out_valid = 1'b1;
                    r.out_index = 8'd1;
                    r.out_value = b;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (s < rdm_len)
            begin
                rx_slot     = s + 1;
                r.out_valid = 1'b1;
                r.out_index = 8'(s);
                r.out_value = b;
                return 1'b1;
            end
            drop_frame();
            r.frame_done = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // offer one word, wait for it to be taken, then maybe idle for a while
    task automatic send_word(input logic k, input logic [7:0] b, input row_check_t chk,
                             input result_t want);
        result_t     r;
        bit          has;
        int unsigned gap;
        in_valid <= 1'b1;
        kind     <= k;
        rx_byte  <= b;
        @(negedge clk);
        while (in_ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        if (k == KIND_BREAK || rx_armed)
            live_words++;
        has = rx_decode(k, b, r);
        if (chk == CHK_WORD)
            due_results.push_back(want);
        else if (chk == CHK_PRED && has)
            due_results.push_back(r);
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 4);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            else
                burst_left--;
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (cfg_ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        if (idx == CFG_FIRST_CHANNEL)
            win_first = data[FIRST_CH_W-1:0];
        else
            win_count = data[CH_COUNT_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one frame attempt: mostly well formed, sometimes cut short, padded or plain noise
    task automatic send_frame(input bit force_dmx);
        int unsigned pick;
        int unsigned stop;
        int unsigned needed;
        int unsigned n;
        int unsigned len;
        pick = force_dmx ? 0 : $urandom_range(0, 99);
        if (force_dmx || pick >= 10)
            send_word(KIND_BREAK, 8'($urandom), CHK_PRED, '0);
        if (pick < 50)
        begin
            stop   = ((win_first == 0) ? 1 : win_first) + win_count;
            needed = (stop <= 1) ? 1 : stop - 1;
            if (needed > SLOT_LIMIT)
                needed = SLOT_LIMIT;
            if (force_dmx || ($urandom_range(0, 99) < 70
                              && (needed <= 64 || $urandom_range(0, 9) == 0)))
            begin
                n = needed;
                if ($urandom_range(0, 3) == 0)
                    n += $urandom_range(1, 2);
            end
            else
                n = $urandom_range(0, needed - 1);
            send_word(KIND_BYTE, SC_DMX, CHK_PRED, '0);
            repeat (n) send_word(KIND_BYTE, 8'($urandom), CHK_PRED, '0);
        end
        else if (pick < 85)
        begin
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
            n   = (len < 2) ? 1 : len - 1;
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(0, n - 1);
            else if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, 2);
            send_word(KIND_BYTE, SC_RDM, CHK_PRED, '0);
            send_word(KIND_BYTE, 8'(len), CHK_PRED, '0);
            repeat (n) send_word(KIND_BYTE, 8'($urandom), CHK_PRED, '0);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                send_word(($urandom_range(0, 3) == 0) ? KIND_BREAK : KIND_BYTE,
                          8'($urandom), CHK_PRED, '0);
        end
    endtask

    function automatic void check_field(input string name, input logic [8:0] want,
                                        input logic [8:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // result side: sampled at the falling edge, taken at the next rising edge
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_ready === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_CAP)
                    $error("unexpected result word: out_index %0d, out_value %0d",
                           out_index, out_value);
            end
            else
            begin
                want = due_results.pop_front();
                check_field("out_valid", 9'(want.out_valid), 9'(out_valid));
                check_field("out_index", 9'(want.out_index), 9'(out_index));
                check_field("out_value", 9'(want.out_value), 9'(out_value));
                check_field("frame_kind", 9'(want.frame_kind), 9'(frame_kind));
                check_field("frame_done", 9'(want.frame_done), 9'(frame_done));
                check_field("frame_abort", 9'(want.frame_abort), 9'(frame_abort));
                check_field("last_of_item", 9'(1'b1), 9'(last_of_item));
            end
        end
    end

    // result side stall pattern, with an occasional long hold-off on request
    initial
    begin
        int unsigned tick;
        int unsigned hold_left;
        int unsigned hold_seen;
        stall_mode_t mode;
        logic [7:0]  mask;
        res_ready = 1'b0;
        tick      = 0;
        hold_left = 0;
        hold_seen = 0;
        mode      = READY_ALWAYS;
        mask      = 8'hFF;
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 48 == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                mask = 8'($urandom) | 8'h01;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES - 1;
                res_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    READY_ALWAYS: res_ready <= 1'b1;
                    READY_HALF:   res_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
                    default:      res_ready <= mask[tick % 8];
                endcase
            end
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned target;
        int unsigned phase_first;
        int unsigned phase_count;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_BYTE;
        rx_byte   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FIRST_CHANNEL;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        steady = 1'b1;
        foreach (script[i])
            send_word(script[i].k, script[i].b, script[i].chk, script[i].want);

        live_words = 0;
        phase      = 0;
        while (live_words < RANDOM_WORDS)
        begin
            settle();
            case (phase)
                0:
                begin
                    // first channel zero and an empty window
                    phase_first = 0;
                    phase_count = 0;
                end
                1:
                begin
                    phase_first = 1;
                    phase_count = 255;
                end
                2:
                begin
                    // window runs past the slot limit
                    phase_first = 511;
                    phase_count = 255;
                end
                3:
                begin
                    phase_first = 300;
                    phase_count = 200;
                end
                default:
                begin
                    phase_first = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                                              : $urandom_range(0, 24);
                    phase_count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                              : $urandom_range(0, 24);
                end
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(CFG_FIRST_CHANNEL, 9'(phase_first));
                write_reg(CFG_CHANNEL_COUNT, {1'($urandom), 8'(phase_count)});
            end
            else
            begin
                write_reg(CFG_CHANNEL_COUNT, {1'($urandom), 8'(phase_count)});
                write_reg(CFG_FIRST_CHANNEL, 9'(phase_first));
            end
            steady     = (phase != 1) && ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(1, 24);
            target     = live_words + PHASE_WORDS;
            if (phase == 1)
                hold_asks++;
            if (phase == 1 || phase == 2)
                send_frame(1'b1);
            while (live_words < target)
                send_frame(1'b0);
            phase++;
        end
        settle();

        if (mismatches == 0)
            $display("dmx_rdm_frame_receiver_tb: done, clean");
        else
            $display("dmx_rdm_frame_receiver_tb: done, errors");
        $finish;
    end

endmodule
